@@ rtl/idfe_pkg.sv @@
// Package for the IMU datagram field extractor: constants, types and position decode.
package idfe_pkg;

  // Packet length in bytes, header included
  localparam int PACKET_BYTES = 38;
  localparam int POS_W        = 6;

  // Register reset values
  localparam logic [7:0]  HEADER_RST       = 8'd147;
  localparam logic [31:0] RATE_GAIN_RST    = 32'd1171267;
  localparam logic [31:0] ACCEL_GAIN_RST   = 32'd20562277;
  localparam logic [31:0] INCLINE_GAIN_RST = 32'd2570554;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_HEADER  = 2'd0;
  localparam logic [1:0] REG_RATE    = 2'd1;
  localparam logic [1:0] REG_ACCEL   = 2'd2;
  localparam logic [1:0] REG_INCLINE = 2'd3;

  // Result kinds
  localparam logic KIND_FIELD = 1'b0;
  localparam logic KIND_SKIP  = 1'b1;

  // Byte phases within a 24-bit field
  localparam logic [1:0] PH_HI  = 2'd0;
  localparam logic [1:0] PH_MID = 2'd1;
  localparam logic [1:0] PH_LO  = 2'd2;

  // Sensor groups
  localparam logic [1:0] GRP_RATE    = 2'd0;
  localparam logic [1:0] GRP_ACCEL   = 2'd1;
  localparam logic [1:0] GRP_INCLINE = 2'd2;

  localparam logic [3:0] LAST_CHAN = 4'd8;

  // What a packet byte position means
  typedef struct packed {
    logic       hit;    // byte belongs to a measurement field
    logic [1:0] phase;  // which byte of the field
    logic [1:0] grp;    // sensor group
    logic [3:0] chan;   // channel number 0..8
  } pos_dec_t;

  function automatic pos_dec_t decode_pos(input logic [POS_W-1:0] p);
    pos_dec_t   d;
    logic [3:0] off;
    d   = '0;
    off = '0;
    if (p >= 6'd1 && p <= 6'd9) begin
      d.hit = 1'b1;
      d.grp = GRP_RATE;
      off   = 4'(p - 6'd1);
    end else if (p >= 6'd11 && p <= 6'd19) begin
      d.hit = 1'b1;
      d.grp = GRP_ACCEL;
      off   = 4'(p - 6'd11);
    end else if (p >= 6'd21 && p <= 6'd29) begin
      d.hit = 1'b1;
      d.grp = GRP_INCLINE;
      off   = 4'(p - 6'd21);
    end
    // offset 0..8 split into field and byte phase
    case (off)
      4'd0, 4'd3, 4'd6: d.phase = PH_HI;
      4'd1, 4'd4, 4'd7: d.phase = PH_MID;
      default:          d.phase = PH_LO;
    endcase
    d.chan = 4'({d.grp, 1'b0}) + 4'(d.grp) + ((off >= 4'd6) ? 4'd2 :
             (off >= 4'd3) ? 4'd1 : 4'd0);
    return d;
  endfunction

endpackage

@@ rtl/imu_datagram_field_extractor_unit.sv @@
// IMU datagram field extractor: byte parser, field gather and fixed-point scaling.
//
// Accepts one serial byte per clock with no gaps needed. While hunting, every
// byte other than the header byte comes out as a skip beat (tuser=1, data zero);
// a header byte starts a packet of idfe_pkg::PACKET_BYTES bytes. The nine
// big-endian 24-bit fields come out as field beats, each on its third byte,
// with the raw value and floor(raw*gain/2^16) saturated to 33 bits. For a result
// beat, the parse result is captured in the parse register at the accepting
// edge, and from there it goes through the 24x33 multiplier and saturation
// into the output register once the output register can take it.
// The two stages hold up to two beats; in_tready drops only while both are
// full and out_tready is low. Other packet bytes produce no beat. The
// registers are written over the APB port at byte addresses 0 (header),
// 4 (rate gain), 8 (accel gain), 12 (incline gain) and should be changed only
// while the block is idle.
module imu_datagram_field_extractor_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [3:0] channel, [27:4] raw_value, [60:28] scaled_value
  output logic        out_tuser,   // [0] kind
  output logic        out_tlast,   // last_field
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers
  logic [7:0]  header_r;
  logic [31:0] rate_gain_r, accel_gain_r, incline_gain_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_r       <= idfe_pkg::HEADER_RST;
      rate_gain_r    <= idfe_pkg::RATE_GAIN_RST;
      accel_gain_r   <= idfe_pkg::ACCEL_GAIN_RST;
      incline_gain_r <= idfe_pkg::INCLINE_GAIN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        idfe_pkg::REG_HEADER:  header_r       <= cfg_pwdata[7:0];
        idfe_pkg::REG_RATE:    rate_gain_r    <= cfg_pwdata;
        idfe_pkg::REG_ACCEL:   accel_gain_r   <= cfg_pwdata;
        idfe_pkg::REG_INCLINE: incline_gain_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Register read mux
  always_comb begin
    unique case (cfg_paddr[3:2])
      idfe_pkg::REG_HEADER:  cfg_prdata = {24'd0, header_r};
      idfe_pkg::REG_RATE:    cfg_prdata = rate_gain_r;
      idfe_pkg::REG_ACCEL:   cfg_prdata = accel_gain_r;
      idfe_pkg::REG_INCLINE: cfg_prdata = incline_gain_r;
      default:               cfg_prdata = '0;
    endcase
  end

  // Pipeline handshake: parse stage s1, output register
  logic s1_valid_r, out_valid_r;
  logic out_adv, s1_adv, in_acc;

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_adv    = !s1_valid_r || out_adv;
  assign in_tready = s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Parser state
  logic                      in_packet_r, in_packet_nxt;
  logic [idfe_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]               pword_r, pword_nxt;

  // Parse result for the stage-1 register
  logic                  res_valid;
  logic                  res_kind;
  logic [3:0]            res_chan;
  logic signed [23:0]    res_raw;
  logic [31:0]           res_gain;
  idfe_pkg::pos_dec_t    dec;
  logic [idfe_pkg::POS_W-1:0] p;

  always_comb begin
    in_packet_nxt = in_packet_r;
    pos_nxt       = pos_r;
    pword_nxt     = pword_r;
    res_valid     = 1'b0;
    res_kind      = idfe_pkg::KIND_FIELD;
    res_chan      = '0;
    res_raw       = '0;
    res_gain      = '0;
    p             = pos_r + 1'b1;
    dec           = idfe_pkg::decode_pos(p);
    if (!in_packet_r) begin
      // hunting for the header
      if (in_tdata == header_r) begin
        in_packet_nxt = 1'b1;
        pos_nxt       = '0;
        pword_nxt     = '0;
      end else begin
        res_valid = 1'b1;
        res_kind  = idfe_pkg::KIND_SKIP;
      end
    end else begin
      pos_nxt = p;
      if (p >= idfe_pkg::POS_W'(idfe_pkg::PACKET_BYTES - 1)) in_packet_nxt = 1'b0;
      if (dec.hit) begin
        case (dec.phase)
          idfe_pkg::PH_HI:  pword_nxt = {8'd0, in_tdata};
          idfe_pkg::PH_MID: pword_nxt = {pword_r[7:0], in_tdata};
          default: begin
            res_valid = 1'b1;
            res_chan  = dec.chan;
            res_raw   = {pword_r, in_tdata};
            case (dec.grp)
              idfe_pkg::GRP_RATE:  res_gain = rate_gain_r;
              idfe_pkg::GRP_ACCEL: res_gain = accel_gain_r;
              default:             res_gain = incline_gain_r;
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      pos_r       <= '0;
      pword_r     <= '0;
    end else if (in_acc) begin
      in_packet_r <= in_packet_nxt;
      pos_r       <= pos_nxt;
      pword_r     <= pword_nxt;
    end
  end

  // Stage 1 register
  logic               s1_kind_r;
  logic [3:0]         s1_chan_r;
  logic signed [23:0] s1_raw_r;
  logic [31:0]        s1_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_acc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      s1_kind_r <= res_kind;
      s1_chan_r <= res_chan;
      s1_raw_r  <= res_raw;
      s1_gain_r <= res_gain;
    end
  end

  // Scale: floor(raw*gain/2^16), saturated to 33 bits signed
  logic signed [56:0] raw_ext, gain_ext, prod;
  logic signed [40:0] quot;
  logic signed [32:0] scaled;

  always_comb begin
    raw_ext  = 57'(s1_raw_r);
    gain_ext = $signed({25'd0, s1_gain_r});
    prod     = raw_ext * gain_ext;
    quot     = prod[56:16];
    if (quot[40:32] == {9{quot[40]}}) begin
      scaled = quot[32:0];
    end else if (quot[40]) begin
      scaled = {1'b1, 32'd0};
    end else begin
      scaled = {1'b0, {32{1'b1}}};
    end
  end

  // Output register
  logic               out_kind_r, out_last_r;
  logic [3:0]         out_chan_r;
  logic signed [23:0] out_raw_r;
  logic signed [32:0] out_scaled_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_kind_r   <= s1_kind_r;
      out_chan_r   <= s1_chan_r;
      out_raw_r    <= s1_raw_r;
      out_scaled_r <= scaled;
      out_last_r   <= (s1_kind_r == idfe_pkg::KIND_FIELD) &&
                      (s1_chan_r == idfe_pkg::LAST_CHAN);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_scaled_r, out_raw_r, out_chan_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
